// ===== sv/vrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared widths, register map and axis codes of the vertex rotate and
// project unit.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TRIG_BITS     = 16;
  localparam int COORD_W       = 32;
  localparam int TRIG_W        = 18;
  localparam int PIX_W         = 12;
  localparam int OP_W          = 2;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  typedef enum logic [2:0] {
    REG_COS   = 3'd0,
    REG_SIN   = 3'd1,
    REG_CAMX  = 3'd2,
    REG_CAMY  = 3'd3,
    REG_CAMZ  = 3'd4,
    REG_FOCAL = 3'd5,
    REG_CENX  = 3'd6,
    REG_CENY  = 3'd7
  } reg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_ROT_Z = 2'd2,
    OP_PASS  = 2'd3
  } op_e;

endpackage

// ===== sv/vertex_rotate_and_project_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_and_project_unit
// Rotates a Q16.16 vertex about one axis and projects it through a pinhole
// camera to saturated screen coordinates.
// ----------------------------------------------------------------------------
//   channel | signals                                  | direction
//   in      | in_valid_i/in_ready_o, opcode, in_x/y/z  | vertex in
//   out     | out_valid_o/out_ready_i, rot, screen, vis| result out
//   cfg     | psel/penable/pwrite/paddr/pwdata/prdata  | APB registers
//
// One vertex per cycle unless the output stalls; the bit-per-stage quotient
// pipeline gives QB bits (QB = max(32, 12 + FRAC_BITS) + 1, 33 by default).
// Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes the whole pipeline; in_ready_o drops with it.
// ----------------------------------------------------------------------------
module vertex_rotate_and_project_unit #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vrp_pkg::ADDR_W-1:0]          paddr,
  input  logic [vrp_pkg::DATA_W-1:0]          pwdata,
  output logic [vrp_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [vrp_pkg::OP_W-1:0]            opcode_i,
  input  logic signed [vrp_pkg::COORD_W-1:0]  in_x_i,
  input  logic signed [vrp_pkg::COORD_W-1:0]  in_y_i,
  input  logic signed [vrp_pkg::COORD_W-1:0]  in_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [vrp_pkg::COORD_W-1:0]  rot_x_o,
  output logic signed [vrp_pkg::COORD_W-1:0]  rot_y_o,
  output logic signed [vrp_pkg::COORD_W-1:0]  rot_z_o,
  output logic signed [vrp_pkg::COORD_W-1:0]  screen_x_o,
  output logic signed [vrp_pkg::COORD_W-1:0]  screen_y_o,
  output logic                                visible_o
);
  import vrp_pkg::*;

  localparam int PROD_W = TRIG_W + COORD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - TRIG_BITS;
  localparam int DEP_W  = COORD_W + 1;
  localparam int NUM_W  = DEP_W + PIX_W + 1;
  localparam int MAG_W  = NUM_W - 1;
  localparam int NW     = MAG_W + FRAC_BITS;
  localparam int QB     = ((COORD_W > PIX_W + FRAC_BITS) ? COORD_W : PIX_W + FRAC_BITS) + 1;
  localparam int HW     = NW - QB;
  localparam int RW     = DEP_W;
  localparam int OS_W   = QB + 2;
  localparam int NEAR   = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic signed [DEP_W-1:0] NEAR_LIM = DEP_W'(NEAR);
  localparam logic signed [SUM_W-1:0] RND_C    = SUM_W'(1) <<< (TRIG_BITS - 1);
  localparam logic signed [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

  // configuration registers
  logic signed [TRIG_W-1:0]  cos_q, sin_q;
  logic signed [COORD_W-1:0] camx_q, camy_q, camz_q;
  logic [PIX_W-1:0]          focal_q, cenx_q, ceny_q;
  logic                      wr_en;
  reg_idx_e                  wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= TRIG_W'(65533);
      sin_q   <= TRIG_W'(655);
      camx_q  <= '0;
      camy_q  <= '0;
      camz_q  <= COORD_W'(6553600);
      focal_q <= PIX_W'(400);
      cenx_q  <= PIX_W'(400);
      ceny_q  <= PIX_W'(200);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_COS:   cos_q   <= pwdata[TRIG_W-1:0];
        REG_SIN:   sin_q   <= pwdata[TRIG_W-1:0];
        REG_CAMX:  camx_q  <= pwdata[COORD_W-1:0];
        REG_CAMY:  camy_q  <= pwdata[COORD_W-1:0];
        REG_CAMZ:  camz_q  <= pwdata[COORD_W-1:0];
        REG_FOCAL: focal_q <= pwdata[PIX_W-1:0];
        REG_CENX:  cenx_q  <= pwdata[PIX_W-1:0];
        REG_CENY:  ceny_q  <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_COS:   prdata = DATA_W'(cos_q);
      REG_SIN:   prdata = DATA_W'(sin_q);
      REG_CAMX:  prdata = DATA_W'(camx_q);
      REG_CAMY:  prdata = DATA_W'(camy_q);
      REG_CAMZ:  prdata = DATA_W'(camz_q);
      REG_FOCAL: prdata = DATA_W'(focal_q);
      REG_CENX:  prdata = DATA_W'(cenx_q);
      REG_CENY:  prdata = DATA_W'(ceny_q);
      default:   prdata = '0;
    endcase
  end

  // pipeline advance
  logic en, out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic v1_q, v2_q, v3_q, v4_q;
  logic vsh_q [QB];

  // stage 1: products
  logic signed [COORD_W-1:0] u1, w1;
  logic [OP_W-1:0]           op1_q;
  logic signed [COORD_W-1:0] x1_q, y1_q, z1_q;
  logic signed [PROD_W-1:0]  pcu_q, psw_q, psu_q, pcw_q;

  always_comb begin
    unique case (op_e'(opcode_i))
      OP_ROT_X: begin u1 = in_y_i; w1 = in_z_i; end
      OP_ROT_Y: begin u1 = in_x_i; w1 = in_z_i; end
      OP_ROT_Z: begin u1 = in_x_i; w1 = in_y_i; end
      default:  begin u1 = in_x_i; w1 = in_y_i; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= opcode_i;
      x1_q  <= in_x_i;
      y1_q  <= in_y_i;
      z1_q  <= in_z_i;
      pcu_q <= cos_q * u1;
      psw_q <= sin_q * w1;
      psu_q <= sin_q * u1;
      pcw_q <= cos_q * w1;
    end
  end

  // stage 2: round, saturate, depth
  logic signed [SUM_W-1:0]   sa2, sb2;
  logic signed [RND_W-1:0]   ra2, rb2;
  logic signed [COORD_W-1:0] qa2, qb2, rx2, ry2, rz2;
  logic signed [DEP_W-1:0]   dep2;
  logic signed [COORD_W-1:0] rx2_q, ry2_q, rz2_q;
  logic signed [DEP_W-1:0]   dep2_q;

  always_comb begin
    sa2 = SUM_W'(pcu_q) - SUM_W'(psw_q) + RND_C;
    sb2 = SUM_W'(psu_q) + SUM_W'(pcw_q) + RND_C;
    ra2 = sa2[SUM_W-1:TRIG_BITS];
    rb2 = sb2[SUM_W-1:TRIG_BITS];
    if ((&ra2[RND_W-1:COORD_W-1]) || !(|ra2[RND_W-1:COORD_W-1])) qa2 = ra2[COORD_W-1:0];
    else qa2 = ra2[RND_W-1] ? C_MIN : C_MAX;
    if ((&rb2[RND_W-1:COORD_W-1]) || !(|rb2[RND_W-1:COORD_W-1])) qb2 = rb2[COORD_W-1:0];
    else qb2 = rb2[RND_W-1] ? C_MIN : C_MAX;
    rx2 = x1_q;
    ry2 = y1_q;
    rz2 = z1_q;
    unique case (op_e'(op1_q))
      OP_ROT_X: begin ry2 = qa2; rz2 = qb2; end
      OP_ROT_Y: begin rx2 = qa2; rz2 = qb2; end
      OP_ROT_Z: begin rx2 = qa2; ry2 = qb2; end
      default: ;
    endcase
    dep2 = DEP_W'(camz_q) - DEP_W'(rz2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx2_q  <= rx2;
      ry2_q  <= ry2;
      rz2_q  <= rz2;
      dep2_q <= dep2;
    end
  end

  // stage 3: numerators
  logic signed [DEP_W-1:0]   dx3, dy3;
  logic signed [PIX_W:0]     foc3;
  logic signed [COORD_W-1:0] rx3_q, ry3_q, rz3_q;
  logic signed [NUM_W-1:0]   nx3_q, ny3_q;
  logic [DEP_W-1:0]          dep3_q;
  logic                      vis3_q;

  assign dx3  = DEP_W'(rx2_q) - DEP_W'(camx_q);
  assign dy3  = DEP_W'(ry2_q) - DEP_W'(camy_q);
  assign foc3 = $signed({1'b0, focal_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      rz3_q  <= rz2_q;
      nx3_q  <= dx3 * foc3;
      ny3_q  <= dy3 * foc3;
      vis3_q <= !dep2_q[DEP_W-1] && (dep2_q != '0) && (dep2_q >= NEAR_LIM);
      dep3_q <= dep2_q;
    end
  end

  // stage 4: magnitudes, divider setup
  logic [MAG_W-1:0] mx4, my4;
  logic [NW-1:0]    dx4, dy4;
  logic [HW-1:0]    hx4, hy4;
  logic [RW-1:0]    dsr4;
  logic signed [COORD_W-1:0] rx4_q, ry4_q, rz4_q;
  logic             vis4_q, negx4_q, negy4_q, ovfx4_q, ovfy4_q;
  logic [RW-1:0]    remx4_q, remy4_q, dsr4_q;
  logic [QB-1:0]    dvdx4_q, dvdy4_q;

  always_comb begin
    mx4  = nx3_q[NUM_W-1] ? MAG_W'(-nx3_q) : MAG_W'(nx3_q);
    my4  = ny3_q[NUM_W-1] ? MAG_W'(-ny3_q) : MAG_W'(ny3_q);
    dx4  = {mx4, {FRAC_BITS{1'b0}}};
    dy4  = {my4, {FRAC_BITS{1'b0}}};
    hx4  = dx4[NW-1:QB];
    hy4  = dy4[NW-1:QB];
    dsr4 = vis3_q ? dep3_q : RW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx4_q   <= rx3_q;
      ry4_q   <= ry3_q;
      rz4_q   <= rz3_q;
      vis4_q  <= vis3_q;
      negx4_q <= nx3_q[NUM_W-1];
      negy4_q <= ny3_q[NUM_W-1];
      ovfx4_q <= ({{RW{1'b0}}, hx4} >= {{HW{1'b0}}, dsr4});
      ovfy4_q <= ({{RW{1'b0}}, hy4} >= {{HW{1'b0}}, dsr4});
      remx4_q <= RW'(hx4);
      remy4_q <= RW'(hy4);
      dvdx4_q <= dx4[QB-1:0];
      dvdy4_q <= dy4[QB-1:0];
      dsr4_q  <= dsr4;
    end
  end

  // quotient pipelines
  logic [QB-1:0] quox, quoy;

  vrp_div_pipe #(.RW(RW), .QB(QB)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remx4_q),
    .dvd_i (dvdx4_q),
    .dsr_i (dsr4_q),
    .quo_o (quox)
  );

  vrp_div_pipe #(.RW(RW), .QB(QB)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remy4_q),
    .dvd_i (dvdy4_q),
    .dsr_i (dsr4_q),
    .quo_o (quoy)
  );

  // side payload alongside the divider
  logic signed [COORD_W-1:0] shx_q [QB];
  logic signed [COORD_W-1:0] shy_q [QB];
  logic signed [COORD_W-1:0] shz_q [QB];
  logic                      shvis_q [QB];
  logic                      shnx_q [QB];
  logic                      shny_q [QB];
  logic                      shox_q [QB];
  logic                      shoy_q [QB];

  always_ff @(posedge clk_i) begin
    if (en) begin
      shx_q[0]   <= rx4_q;
      shy_q[0]   <= ry4_q;
      shz_q[0]   <= rz4_q;
      shvis_q[0] <= vis4_q;
      shnx_q[0]  <= negx4_q;
      shny_q[0]  <= negy4_q;
      shox_q[0]  <= ovfx4_q;
      shoy_q[0]  <= ovfy4_q;
      for (int i = 1; i < QB; i++) begin
        shx_q[i]   <= shx_q[i-1];
        shy_q[i]   <= shy_q[i-1];
        shz_q[i]   <= shz_q[i-1];
        shvis_q[i] <= shvis_q[i-1];
        shnx_q[i]  <= shnx_q[i-1];
        shny_q[i]  <= shny_q[i-1];
        shox_q[i]  <= shox_q[i-1];
        shoy_q[i]  <= shoy_q[i-1];
      end
    end
  end

  // output stage
  logic signed [QB:0]        sqx, sqy;
  logic signed [OS_W-1:0]    sumx, sumy;
  logic signed [COORD_W-1:0] scx, scy;

  always_comb begin
    sqx  = shnx_q[QB-1] ? -$signed({1'b0, quox}) : $signed({1'b0, quox});
    sqy  = shny_q[QB-1] ? -$signed({1'b0, quoy}) : $signed({1'b0, quoy});
    sumx = OS_W'(sqx) + $signed({{(OS_W-PIX_W-FRAC_BITS){1'b0}}, cenx_q, {FRAC_BITS{1'b0}}});
    sumy = OS_W'(sqy) + $signed({{(OS_W-PIX_W-FRAC_BITS){1'b0}}, ceny_q, {FRAC_BITS{1'b0}}});
    if (!shvis_q[QB-1]) scx = '0;
    else if (shox_q[QB-1]) scx = shnx_q[QB-1] ? C_MIN : C_MAX;
    else if ((&sumx[OS_W-1:COORD_W-1]) || !(|sumx[OS_W-1:COORD_W-1])) scx = sumx[COORD_W-1:0];
    else scx = sumx[OS_W-1] ? C_MIN : C_MAX;
    if (!shvis_q[QB-1]) scy = '0;
    else if (shoy_q[QB-1]) scy = shny_q[QB-1] ? C_MIN : C_MAX;
    else if ((&sumy[OS_W-1:COORD_W-1]) || !(|sumy[OS_W-1:COORD_W-1])) scy = sumy[COORD_W-1:0];
    else scy = sumy[OS_W-1] ? C_MIN : C_MAX;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_x_o    <= shx_q[QB-1];
      rot_y_o    <= shy_q[QB-1];
      rot_z_o    <= shz_q[QB-1];
      screen_x_o <= scx;
      screen_y_o <= scy;
      visible_o  <= shvis_q[QB-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < QB; i++) begin
        vsh_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      vsh_q[0] <= v4_q;
      for (int i = 1; i < QB; i++) begin
        vsh_q[i] <= vsh_q[i-1];
      end
      out_valid_q <= vsh_q[QB-1];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/vrp_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_div_pipe
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module vrp_div_pipe #(
  parameter int RW = 33,
  parameter int QB = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] rem_i,
  input  logic [QB-1:0] dvd_i,
  input  logic [RW-1:0] dsr_i,
  output logic [QB-1:0] quo_o
);

  logic [RW-1:0] rem_q [QB];
  logic [QB-1:0] dvd_q [QB];
  logic [RW-1:0] dsr_q [QB];
  logic [QB-1:0] quo_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] rem_p;
    logic [QB-1:0] dvd_p;
    logic [RW-1:0] dsr_p;
    logic [QB-1:0] quo_p;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = rem_i;
      assign dvd_p = dvd_i;
      assign dsr_p = dsr_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign dvd_p = dvd_q[k-1];
      assign dsr_p = dsr_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign trial = {rem_p, dvd_p[QB-1-k]};
    assign diff  = trial - {1'b0, dsr_p};
    assign ge    = (trial >= {1'b0, dsr_p});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[RW-1:0] : trial[RW-1:0];
        dvd_q[k] <= dvd_p;
        dsr_q[k] <= dsr_p;
        quo_q[k] <= {quo_p[QB-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

// ===== sv/vrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_checker
// Port-level checks of the vertex rotate and project unit.
// ----------------------------------------------------------------------------
module vrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] screen_x_o,
  input logic [31:0] screen_y_o,
  input logic        visible_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(screen_x_o))
    else $error("result dropped while stalled");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("hidden vertex with screen position");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind vertex_rotate_and_project_unit vrp_checker u_vrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .screen_x_o  (screen_x_o),
  .screen_y_o  (screen_y_o),
  .visible_o   (visible_o)
);

// ===== tb/vertex_rotate_and_project_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_and_project_unit_tb
// Streams vertices through the rotate and project unit across several camera
// and angle settings. Each result is compared field by field against a
// built-in predictor or directed table, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module vertex_rotate_and_project_unit_tb;
  import vrp_pkg::*;

  typedef struct packed {
    int rot_x;
    int rot_y;
    int rot_z;
    int scr_x;
    int scr_y;
    bit vis;
  } vtx_res_t;

  typedef struct {
    op_e      op;
    int       x;
    int       y;
    int       z;
    bit       typed;
    vtx_res_t res;
  } vtx_row_t;

  localparam int  ONE_Q     = 1 << FRAC_BITS_DEF;
  localparam int  NEAR_Q    = (ONE_Q + 500) / 1000;
  localparam int  N_PHASES  = 8;
  localparam int  PHASE_LEN = 220;
  localparam int  STALL_MAX = 5000;
  localparam int  HOLD_LEN  = 300;
  localparam int  IMAX      = 32'sh7fff_ffff;
  localparam int  IMIN      = 32'sh8000_0000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        psel, penable, pwrite;
  logic [ADDR_W-1:0]           paddr;
  logic [DATA_W-1:0]           pwdata;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [OP_W-1:0]             opcode_i;
  logic signed [COORD_W-1:0]   in_x_i, in_y_i, in_z_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [COORD_W-1:0]   rot_x_o, rot_y_o, rot_z_o, screen_x_o, screen_y_o;
  logic                        visible_o;

  vertex_rotate_and_project_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint   cfg_reg [8];
  vtx_res_t projected_q [$];
  int       errors;
  int       n_vertices;
  int       n_results;
  int       n_hidden;
  int       stall_cycles;
  bit       quiet;
  bit       hold_req;

  function automatic longint sat32(longint v);
    if (v > longint'(IMAX)) return longint'(IMAX);
    if (v < longint'(IMIN)) return longint'(IMIN);
    return v;
  endfunction

  function automatic longint rot_mac(longint a, longint p, longint b, longint q);
    longint sum;
    sum = a * p + b * q + (longint'(1) << (TRIG_BITS - 1));
    return sat32(sum >>> TRIG_BITS);
  endfunction

  function automatic longint project_axis(longint coord, longint cam, longint centre,
                                          longint depth);
    longint num, quo, rem;
    num = (coord - cam) * cfg_reg[REG_FOCAL];
    quo = num / depth;
    rem = num % depth;
    if (quo > (longint'(1) << 38)) quo = longint'(1) << 38;
    if (quo < -(longint'(1) << 38)) quo = -(longint'(1) << 38);
    return sat32(centre * ONE_Q + quo * ONE_Q + (rem * ONE_Q) / depth);
  endfunction

  function automatic vtx_res_t rotate_project(op_e op, int x, int y, int z);
    vtx_res_t r;
    longint   c, s, rx, ry, rz, depth;
    c  = cfg_reg[REG_COS];
    s  = cfg_reg[REG_SIN];
    rx = x;
    ry = y;
    rz = z;
    case (op)
      OP_ROT_X: begin
        ry = rot_mac(c, y, -s, z);
        rz = rot_mac(s, y, c, z);
      end
      OP_ROT_Y: begin
        rx = rot_mac(c, x, -s, z);
        rz = rot_mac(s, x, c, z);
      end
      OP_ROT_Z: begin
        rx = rot_mac(c, x, -s, y);
        ry = rot_mac(s, x, c, y);
      end
      default: ;
    endcase
    depth = cfg_reg[REG_CAMZ] - rz;
    r = '0;
    r.rot_x = int'(rx);
    r.rot_y = int'(ry);
    r.rot_z = int'(rz);
    if (depth >= NEAR_Q && depth > 0) begin
      r.vis   = 1'b1;
      r.scr_x = int'(project_axis(rx, cfg_reg[REG_CAMX], cfg_reg[REG_CENX], depth));
      r.scr_y = int'(project_axis(ry, cfg_reg[REG_CAMY], cfg_reg[REG_CENY], depth));
    end
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_COS, REG_SIN: cfg_reg[idx] = longint'($signed(val[TRIG_W-1:0]));
      REG_CAMX, REG_CAMY, REG_CAMZ: cfg_reg[idx] = longint'($signed(val));
      default: cfg_reg[idx] = longint'(val[PIX_W-1:0]);
    endcase
  endtask

  task automatic send_vertex(op_e op, int x, int y, int z, bit typed, vtx_res_t tres);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    in_x_i     <= x;
    in_y_i     <= y;
    in_z_i     <= z;
    do @(posedge clk_i); while (!in_ready_o);
    projected_q.push_back(typed ? tres : rotate_project(op, x, y, z));
    n_vertices++;
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return int'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return IMAX;
          1: return IMIN;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
    endcase
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    vtx_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (projected_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual rot_x %0d", $time,
                 rot_x_o);
        errors++;
      end else begin
        e = projected_q.pop_front();
        if (!e.vis) n_hidden++;
        check_field("rot_x", e.rot_x, rot_x_o);
        check_field("rot_y", e.rot_y, rot_y_o);
        check_field("rot_z", e.rot_z, rot_z_o);
        check_field("screen_x", e.scr_x, screen_x_o);
        check_field("screen_y", e.scr_y, screen_y_o);
        check_field("visible", e.vis, visible_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_MAX);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  vtx_row_t    dir_rows [];
  logic [31:0] phase_cfg [8];
  vtx_res_t    none;

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_ROT_X;
    in_x_i       = '0;
    in_y_i       = '0;
    in_z_i       = '0;
    errors       = 0;
    n_vertices   = 0;
    n_results    = 0;
    n_hidden     = 0;
    stall_cycles = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    none         = '0;
    cfg_reg = '{65533, 655, 0, 0, 6553600, 400, 400, 200};
    dir_rows = '{
      '{OP_PASS, 0, 0, 0, 1'b1, '{0, 0, 0, 26214400, 13107200, 1'b1}},
      '{OP_PASS, 0, 0, 6553600, 1'b1, '{0, 0, 6553600, 0, 0, 1'b0}},
      '{OP_PASS, 0, 0, 6553535, 1'b1, '{0, 0, 6553535, 0, 0, 1'b0}},
      '{OP_PASS, 0, 0, 6553534, 1'b1, '{0, 0, 6553534, 26214400, 13107200, 1'b1}},
      '{OP_PASS, 0, 0, IMAX, 1'b1, '{0, 0, IMAX, 0, 0, 1'b0}},
      '{OP_PASS, 0, 0, IMIN, 1'b1, '{0, 0, IMIN, 26214400, 13107200, 1'b1}},
      '{OP_ROT_X, 65536, 131072, -196608, 1'b0, none},
      '{OP_ROT_Y, 65536, 131072, -196608, 1'b0, none},
      '{OP_ROT_Z, 65536, 131072, -196608, 1'b0, none},
      '{OP_ROT_X, IMAX, IMAX, IMAX, 1'b0, none},
      '{OP_ROT_Y, IMAX, IMAX, IMAX, 1'b0, none},
      '{OP_ROT_Z, IMAX, IMAX, IMAX, 1'b0, none},
      '{OP_PASS, IMAX, IMAX, IMAX, 1'b0, none},
      '{OP_ROT_X, IMIN, IMIN, IMIN, 1'b0, none},
      '{OP_ROT_Y, IMIN, IMIN, IMIN, 1'b0, none},
      '{OP_ROT_Z, IMIN, IMIN, IMIN, 1'b0, none},
      '{OP_PASS, IMIN, IMIN, IMIN, 1'b0, none},
      '{OP_PASS, IMAX, IMIN, 0, 1'b0, none},
      '{OP_ROT_Z, -1, 1, 0, 1'b0, none},
      '{OP_ROT_X, -1, -1, -1, 1'b0, none}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_vertex(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                  dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        in_valid_i <= 1'b0;
        while (projected_q.size() != 0) @(posedge clk_i);
        case (p)
          1: phase_cfg = '{32'h1_0000, 0, 0, 0, 6553600, 400, 400, 200};
          2: phase_cfg = '{32'h3_0000, 32'h1_0000, IMAX, IMIN, IMIN, 4095, 4095, 0};
          3: phase_cfg = '{32'h1_FFFF, 32'h2_0000, -1, 1, IMAX, 1, 0, 4095};
          4: phase_cfg = '{46341, 46341, 32'h0001_0000, 32'hFFFF_0000, 32'h0100_0000,
                           0, 2048, 2048};
          7: phase_cfg = '{65533, 655, 0, 0, 32'h0032_0000, 800, 320, 240};
          default: begin
            foreach (phase_cfg[k]) phase_cfg[k] = $urandom;
            phase_cfg[REG_CAMZ] = $urandom_range(0, 32'h0400_0000);
          end
        endcase
        if (p == N_PHASES - 1) quiet = 1'b1;
        for (int k = 0; k < 8; k++) write_reg(reg_idx_e'(k), phase_cfg[k]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk_i);
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 1 && n == 20) hold_req = 1'b1;
        if (p == 2 && n == 100) begin
          in_valid_i <= 1'b0;
          while (projected_q.size() != 0) @(posedge clk_i);
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk_i);
        end
        send_vertex(op_e'(($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2)),
                    rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
      end
    end
    in_valid_i <= 1'b0;

    while (projected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d vertices over %0d register settings; %0d results, %0d hidden.",
             n_vertices, N_PHASES, n_results, n_hidden);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
